@@ hdl/tpwm_pkg.sv @@
// shared types and constants of the three-phase sine pwm generator
`default_nettype none

package tpwm_pkg;

	localparam int PHASE_W = 16;
	localparam int DUTY_W  = 12;
	localparam int AMP_W   = 12;
	localparam int SINE_W  = 15;
	localparam int CFG_AW  = 4;
	localparam int CFG_DW  = 32;

	// one third and two thirds of a turn
	localparam logic [PHASE_W-1:0] SHIFT_120 = 16'd21845;
	localparam logic [PHASE_W-1:0] SHIFT_240 = 16'd43691;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [AMP_W-1:0]   amplitude;
		logic [DUTY_W-1:0]  offset;
	} cfg_t;

	// per-stage load enables of the lanes
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ hdl/tpwm_ifs.sv @@
// valid/ready channel interfaces for tick beats and duty beats
`default_nettype none

interface tpwm_tick_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface tpwm_duty_if import tpwm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;
	logic [DUTY_W-1:0] duty_c;

	modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
	modport sink (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

`default_nettype wire

@@ hdl/tpwm_cfg.sv @@
// apb register bank: phase step, amplitude and offset
`default_nettype none

module tpwm_cfg import tpwm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	localparam logic [1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
	localparam logic [1:0] REG_OFFSET     = 2'd2;

	localparam logic [AMP_W-1:0]  AMP_RESET = 12'd2048;
	localparam logic [DUTY_W-1:0] OFS_RESET = 12'd2048;

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= '0;
			cfg_q.amplitude  <= AMP_RESET;
			cfg_q.offset     <= OFS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PHASE_STEP: cfg_q.phase_step <= pwdata[PHASE_W-1:0];
				REG_AMPLITUDE:  cfg_q.amplitude  <= pwdata[AMP_W-1:0];
				REG_OFFSET:     cfg_q.offset     <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PHASE_STEP: prdata = CFG_DW'(cfg_q.phase_step);
			REG_AMPLITUDE:  prdata = CFG_DW'(cfg_q.amplitude);
			REG_OFFSET:     prdata = CFG_DW'(cfg_q.offset);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/tpwm_rom.sv @@
// quarter-wave sine rom in q1.14, contents built at elaboration
`default_nettype none

module tpwm_rom import tpwm_pkg::*; #(
	parameter int SINE_ENTRIES = 256,
	parameter int AW = $clog2(SINE_ENTRIES + 1)
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [AW-1:0]     addr,
	output logic      [SINE_W-1:0] data
);

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_MAX    = 64'd16384;
	localparam logic [7:0] TAYLOR_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	typedef logic [SINE_W-1:0] rom_t [SINE_ENTRIES+1];

	// truncating taylor series of sin(pi/2 * k / n) in q30, rounded to q14
	function automatic logic [SINE_W-1:0] quarter_sine(input int k);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] r;
		logic [63:0] s;
		t = (HALF_PI_Q30 * 64'(k) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
		t2 = (t * t) >> 30;
		r = ONE_Q30;
		for (int i = 0; i < 6; i++) begin
			r = ONE_Q30 - (((t2 * r) >> 30) / 64'(TAYLOR_DIV[i]));
		end
		s = (t * r) >> 30;
		s = (s + 64'd32768) >> 16;
		if (s > SINE_MAX) begin
			s = SINE_MAX;
		end
		return s[SINE_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t tab;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			tab[k] = quarter_sine(k);
		end
		return tab;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= ROM[addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/tpwm_lane.sv @@
// one phase lane: table address, rom read, amplitude scale, offset and clamp
`default_nettype none

module tpwm_lane import tpwm_pkg::*; #(
	parameter int PWM_BITS = 12,
	parameter int SINE_ENTRIES = 256
) (
	input  wire logic               clk,
	input  wire pipe_ctl_t          ctl,
	input  wire cfg_t               cfg,
	input  wire logic [PHASE_W-1:0] phase_s1,
	output logic      [DUTY_W-1:0]  duty_s5
);

	localparam int AW   = $clog2(SINE_ENTRIES + 1);
	localparam int MW   = 14 + AW;
	localparam int MAG_W = SINE_W + AMP_W;
	localparam int SV_W = MAG_W + 1;
	localparam int RND_W = SV_W - 14;
	localparam int D_W  = 16;
	localparam int MAXV = (1 << PWM_BITS) - 1;

	logic [MW-1:0]       k_prod;
	logic [AW-1:0]       k_idx;
	logic [AW-1:0]       addr_d;
	logic [AW-1:0]       addr_s2;
	logic                neg_s2;
	logic [SINE_W-1:0]   sine_s3;
	logic                neg_s3;
	logic [MAG_W-1:0]    mag_s4;
	logic                neg_s4;
	logic [SV_W-1:0]     mag_ext;
	logic [SV_W-1:0]     sv;
	logic [SV_W-1:0]     sv_rnd;
	logic [RND_W-1:0]    rnd;
	logic signed [D_W-1:0] d;
	logic [DUTY_W-1:0]   duty_d;

	// position inside the quadrant, scaled to the table size
	assign k_prod = {{AW{1'b0}}, phase_s1[13:0]} * MW'(SINE_ENTRIES);
	assign k_idx  = k_prod[MW-1:14];
	assign addr_d = phase_s1[14] ? (AW'(SINE_ENTRIES) - k_idx) : k_idx;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			addr_s2 <= addr_d;
			neg_s2  <= phase_s1[15];
		end
	end

	tpwm_rom #(
		.SINE_ENTRIES (SINE_ENTRIES),
		.AW           (AW)
	) u_rom (
		.clk  (clk),
		.en   (ctl.en_s3),
		.addr (addr_s2),
		.data (sine_s3)
	);

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			neg_s3 <= neg_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			mag_s4 <= MAG_W'(sine_s3) * MAG_W'(cfg.amplitude);
			neg_s4 <= neg_s3;
		end
	end

	// round half up, then offset and clamp to the pwm range
	assign mag_ext = {1'b0, mag_s4};
	assign sv      = neg_s4 ? (~mag_ext + SV_W'(1)) : mag_ext;
	assign sv_rnd  = sv + SV_W'(8192);
	assign rnd     = sv_rnd[SV_W-1:14];
	assign d       = signed'({{(D_W-DUTY_W){1'b0}}, cfg.offset})
	               + signed'({{(D_W-RND_W){rnd[RND_W-1]}}, rnd});

	always_comb begin
		if (d < 0) begin
			duty_d = '0;
		end else if (d > MAXV) begin
			duty_d = DUTY_W'(MAXV);
		end else begin
			duty_d = d[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			duty_s5 <= duty_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/three_phase_sine_pwm.sv @@
// top level: phase accumulator, stage valids and three duty lanes
//
// channel   dir  beat                          handshake
// tick      in   advance                       valid/ready
// duty      out  duty_a, duty_b, duty_c        valid/ready
// apb       in   phase_step, amplitude, offset psel/penable/pwrite, pready tied high
//
// one tick beat per cycle while the duty output is not stalled; its duty beat becomes valid
// after the input register and four lane stages (address, rom read, multiply, clamp)
// reset clears the stage valids and the phase, and loads the register defaults
// a stalled output holds its stage; earlier stages keep filling until they are full
`default_nettype none

module three_phase_sine_pwm import tpwm_pkg::*; #(
	parameter int PWM_BITS = 12,
	parameter int SINE_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tpwm_tick_if.sink              tick,
	tpwm_duty_if.source            duty,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t               cfg;
	pipe_ctl_t          ctl;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_nxt;
	logic [PHASE_W-1:0] pa_s1;
	logic [PHASE_W-1:0] pb_s1;
	logic [PHASE_W-1:0] pc_s1;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic               acc;

	tpwm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a stage takes new data when empty or when the next one moves
	assign rdy_s5 = !v_s5 || duty.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign ctl.en_s2 = rdy_s2;
	assign ctl.en_s3 = rdy_s3;
	assign ctl.en_s4 = rdy_s4;
	assign ctl.en_s5 = rdy_s5;

	assign tick.ready = rdy_s1;
	assign acc        = tick.valid && rdy_s1;
	assign phase_nxt  = tick.advance ? (phase_q + cfg.phase_step) : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			if (acc) begin
				phase_q <= phase_nxt;
			end
			if (rdy_s1) v_s1 <= tick.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pa_s1 <= phase_nxt;
			pb_s1 <= phase_nxt + SHIFT_120;
			pc_s1 <= phase_nxt + SHIFT_240;
		end
	end

	tpwm_lane #(.PWM_BITS(PWM_BITS), .SINE_ENTRIES(SINE_ENTRIES)) u_lane_a (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.phase_s1 (pa_s1),
		.duty_s5  (duty.duty_a)
	);

	tpwm_lane #(.PWM_BITS(PWM_BITS), .SINE_ENTRIES(SINE_ENTRIES)) u_lane_b (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.phase_s1 (pb_s1),
		.duty_s5  (duty.duty_b)
	);

	tpwm_lane #(.PWM_BITS(PWM_BITS), .SINE_ENTRIES(SINE_ENTRIES)) u_lane_c (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.phase_s1 (pc_s1),
		.duty_s5  (duty.duty_c)
	);

	assign duty.valid = v_s5;

`ifndef NO_ASSERTIONS
	// phase moves only on an accepted beat
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(phase_q))
		else $error("phase changed without an accepted beat");

	a_no_advance: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !tick.advance |=> $stable(phase_q))
		else $error("phase changed on a beat without advance");

	// stage one carries the phase just committed
	a_s1_phase: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (pa_s1 == phase_q) && v_s1)
		else $error("stage one phase differs from accumulator");

	// a full pipe behind a stalled output takes no beat
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !duty.ready |-> !tick.ready)
		else $error("beat taken into a full stalled pipe");
`endif

endmodule

`default_nettype wire
